[rtl/ptcr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the page table with clock replacement.
// No dependencies; every other file of the block refers to it by scoped names.
package ptcr_pkg;

  // Fixed field widths of the request and result channels.
  localparam int OPCODE_W = 3;
  localparam int VADDR_W  = 24;
  localparam int COUNT_W  = 15;
  localparam int FLAGS_W  = 2;
  localparam int FNUM_W   = 22;
  localparam int STATUS_W = 2;
  localparam int PHYS_W   = 32;

  // Request opcodes.
  localparam logic [OPCODE_W-1:0] OP_ACCESS  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_MAP     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_UNMAP   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_INSTALL = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_EVICT   = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRAP     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAULT    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOVICTIM = 2'd3;

  // Bit positions inside a table entry; the frame number starts at E_FRAME_LSB.
  localparam int E_FLAGS_LSB = 0;
  localparam int E_MAPPED    = 2;
  localparam int E_ACCESSED  = 3;
  localparam int E_DIRTY     = 4;
  localparam int E_FRAME_LSB = 5;

  // Which kind of result the datapath stages.
  typedef enum logic [2:0] {
    RES_OK       = 3'd0,
    RES_TRAP     = 3'd1,
    RES_FAULT    = 3'd2,
    RES_NOVICTIM = 3'd3,
    RES_ACCESS   = 3'd4,
    RES_VICTIM   = 3'd5
  } res_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_req;  // latch the incoming request
    logic clr_wr;    // write a zero entry at the sweep pointer and advance
    logic ptr_init;  // load the sweep pointer and run length from the request
    logic rd_ptr;    // read at the sweep pointer and advance
    logic wr_fill;   // write the run fill value at the sweep pointer and advance
    logic wr_page;   // write back the updated entry of the request page
    logic rd_hand;   // read the entry under the clock hand
    logic ev_start;  // clear the visit count
    logic ev_visit;  // settle the entry under the hand and advance the hand
    logic set_res;   // stage a result of kind res_kind
    res_e res_kind;
    logic push_out;  // move the staged result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic aligned;
    logic run_fits;
    logic page_in;
    logic va_nonzero;
    logic cnt_zero;
    logic left_last;
    logic e_mapped;
    logic e_resident;
    logic e_accessed;
    logic clash;
    logic ev_last;
    logic init_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/ptcr_req_if.sv]
`timescale 1ns / 1ps
// Request channel of the page table: valid/ready handshake plus request fields.
// Depends on ptcr_pkg for the field widths.
interface ptcr_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptcr_pkg::OPCODE_W-1:0] opcode;
  logic [ptcr_pkg::VADDR_W-1:0]  vaddr;
  logic                          is_write;
  logic [ptcr_pkg::COUNT_W-1:0]  page_count;
  logic [ptcr_pkg::FLAGS_W-1:0]  access_flags;
  logic [ptcr_pkg::FNUM_W-1:0]   frame_number;

  modport source (
    output valid, opcode, vaddr, is_write, page_count, access_flags, frame_number,
    input  ready
  );
  modport sink (
    input  valid, opcode, vaddr, is_write, page_count, access_flags, frame_number,
    output ready
  );
endinterface

[rtl/ptcr_rsp_if.sv]
`timescale 1ns / 1ps
// Result channel of the page table: valid/ready handshake plus result fields.
// Depends on ptcr_pkg for the field widths.
interface ptcr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ptcr_pkg::STATUS_W-1:0] status;
  logic [ptcr_pkg::PHYS_W-1:0]   phys_addr;
  logic [ptcr_pkg::VADDR_W-1:0]  victim_vaddr;
  logic [ptcr_pkg::FNUM_W-1:0]   victim_frame;
  logic                          victim_was_dirty;

  modport source (
    output valid, status, phys_addr, victim_vaddr, victim_frame, victim_was_dirty,
    input  ready
  );
  modport sink (
    input  valid, status, phys_addr, victim_vaddr, victim_frame, victim_was_dirty,
    output ready
  );
endinterface

[rtl/ptcr_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the page table: one-hot state machine that sequences each request.
// Depends on ptcr_pkg for the command and status structs and the opcodes.
module ptcr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ptcr_pkg::sts_t   sts_i,
  output ptcr_pkg::cmd_t   cmd_o
);

  typedef enum logic [8:0] {
    S_INIT       = 9'b000000001,
    S_IDLE       = 9'b000000010,
    S_DISPATCH   = 9'b000000100,
    S_MAP_SCAN   = 9'b000001000,
    S_MAP_DECIDE = 9'b000010000,
    S_FILL       = 9'b000100000,
    S_EV_READ    = 9'b001000000,
    S_EV_CHECK   = 9'b010000000,
    S_PUSH       = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    unique case (state_q)
      S_INIT: begin
        // Clearing pass: one entry per cycle until the last one is written.
        cmd_o.clr_wr = 1'b1;
        if (sts_i.init_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_req = 1'b1;
          state_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d        = S_PUSH;
        cmd_o.set_res  = 1'b1;
        cmd_o.res_kind = ptcr_pkg::RES_TRAP;
        unique case (sts_i.op)
          ptcr_pkg::OP_ACCESS: begin
            if (sts_i.page_in && sts_i.e_mapped && sts_i.e_resident) begin
              cmd_o.wr_page  = 1'b1;
              cmd_o.res_kind = ptcr_pkg::RES_ACCESS;
            end else begin
              cmd_o.res_kind = ptcr_pkg::RES_FAULT;
            end
          end
          ptcr_pkg::OP_MAP, ptcr_pkg::OP_UNMAP: begin
            if (sts_i.aligned && sts_i.run_fits) begin
              if (sts_i.cnt_zero) begin
                cmd_o.res_kind = ptcr_pkg::RES_OK;
              end else begin
                cmd_o.set_res  = 1'b0;
                cmd_o.ptr_init = 1'b1;
                state_d = (sts_i.op == ptcr_pkg::OP_MAP) ? S_MAP_SCAN : S_FILL;
              end
            end
          end
          ptcr_pkg::OP_INSTALL: begin
            if (sts_i.va_nonzero && sts_i.page_in && sts_i.e_mapped) begin
              cmd_o.wr_page  = 1'b1;
              cmd_o.res_kind = ptcr_pkg::RES_OK;
            end
          end
          ptcr_pkg::OP_EVICT: begin
            cmd_o.set_res  = 1'b0;
            cmd_o.ev_start = 1'b1;
            state_d        = S_EV_READ;
          end
          default: begin
            cmd_o.res_kind = ptcr_pkg::RES_TRAP;
          end
        endcase
      end
      S_MAP_SCAN: begin
        cmd_o.rd_ptr = 1'b1;
        if (sts_i.left_last) begin
          state_d = S_MAP_DECIDE;
        end
      end
      S_MAP_DECIDE: begin
        if (sts_i.clash) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = ptcr_pkg::RES_TRAP;
          state_d        = S_PUSH;
        end else begin
          cmd_o.ptr_init = 1'b1;
          state_d        = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.wr_fill = 1'b1;
        if (sts_i.left_last) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = ptcr_pkg::RES_OK;
          state_d        = S_PUSH;
        end
      end
      S_EV_READ: begin
        cmd_o.rd_hand = 1'b1;
        state_d       = S_EV_CHECK;
      end
      S_EV_CHECK: begin
        cmd_o.ev_visit = 1'b1;
        if (sts_i.e_resident && !sts_i.e_accessed) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = ptcr_pkg::RES_VICTIM;
          state_d        = S_PUSH;
        end else if (sts_i.ev_last) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_kind = ptcr_pkg::RES_NOVICTIM;
          state_d        = S_PUSH;
        end else begin
          state_d = S_EV_READ;
        end
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/ptcr_dp.sv]
`timescale 1ns / 1ps
// Datapath of the page table: entry memory, clock hand, sweep counters and result registers.
// Depends on ptcr_pkg for the command and status structs, codes and entry layout.
module ptcr_dp #(
  parameter int TABLE_ENTRIES    = 16384,
  parameter int PAGE_OFFSET_BITS = 10,
  parameter int FRAME_BITS       = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptcr_pkg::cmd_t                cmd_i,
  output ptcr_pkg::sts_t                sts_o,
  input  logic [ptcr_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [ptcr_pkg::VADDR_W-1:0]  vaddr_i,
  input  logic                          is_write_i,
  input  logic [ptcr_pkg::COUNT_W-1:0]  page_count_i,
  input  logic [ptcr_pkg::FLAGS_W-1:0]  access_flags_i,
  input  logic [ptcr_pkg::FNUM_W-1:0]   frame_number_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ptcr_pkg::STATUS_W-1:0] status_o,
  output logic [ptcr_pkg::PHYS_W-1:0]   phys_addr_o,
  output logic [ptcr_pkg::VADDR_W-1:0]  victim_vaddr_o,
  output logic [ptcr_pkg::FNUM_W-1:0]   victim_frame_o,
  output logic                          victim_was_dirty_o
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int VW = $clog2(2 * TABLE_ENTRIES);
  localparam int EW = FRAME_BITS + ptcr_pkg::E_FRAME_LSB;
  localparam int PW = ptcr_pkg::VADDR_W - PAGE_OFFSET_BITS;

  // Latched request.
  logic [ptcr_pkg::OPCODE_W-1:0] op_q;
  logic [ptcr_pkg::VADDR_W-1:0]  va_q;
  logic                          wr_q;
  logic [ptcr_pkg::COUNT_W-1:0]  cnt_q;
  logic [ptcr_pkg::FLAGS_W-1:0]  flags_q;
  logic [FRAME_BITS-1:0]         fno_q;

  logic [EW-1:0] mem_q [TABLE_ENTRIES];
  logic [EW-1:0] rdata_q;
  logic [IW-1:0] raddr, waddr;
  logic [EW-1:0] wdata;
  logic          we;

  logic [IW-1:0]                ptr_q, ptr_d;
  logic [ptcr_pkg::COUNT_W-1:0] left_q, left_d;
  logic [IW-1:0]                hand_q, hand_d, hand_next;
  logic [VW-1:0]                visits_q, visits_d;
  logic                         scan_pend_q, clash_q, clash_d;

  logic [PW-1:0]         page;
  logic [IW-1:0]         page_idx;
  logic [31:0]           run_end;
  logic [FRAME_BITS-1:0] e_frame;
  logic                  e_resident;

  // Staged result and output register.
  logic [ptcr_pkg::STATUS_W-1:0] res_st_q, res_st_d;
  logic [ptcr_pkg::PHYS_W-1:0]   res_pa_q, res_pa_d;
  logic [ptcr_pkg::VADDR_W-1:0]  res_vva_q, res_vva_d;
  logic [ptcr_pkg::FNUM_W-1:0]   res_vfr_q, res_vfr_d;
  logic                          res_vdt_q, res_vdt_d;
  logic                          out_valid_q;
  logic [ptcr_pkg::STATUS_W-1:0] out_st_q;
  logic [ptcr_pkg::PHYS_W-1:0]   out_pa_q;
  logic [ptcr_pkg::VADDR_W-1:0]  out_vva_q;
  logic [ptcr_pkg::FNUM_W-1:0]   out_vfr_q;
  logic                          out_vdt_q;

  assign page       = va_q[ptcr_pkg::VADDR_W-1:PAGE_OFFSET_BITS];
  assign page_idx   = IW'(page);
  assign run_end    = 32'(page) + 32'(cnt_q);
  assign e_frame    = rdata_q[EW-1:ptcr_pkg::E_FRAME_LSB];
  assign e_resident = (e_frame != '0);
  assign hand_next  = (hand_q == IW'(TABLE_ENTRIES - 1)) ? '0 : hand_q + 1'b1;

  always_comb begin
    sts_o            = '0;
    sts_o.op         = op_q;
    sts_o.aligned    = (va_q[PAGE_OFFSET_BITS-1:0] == '0);
    sts_o.run_fits   = (run_end <= 32'(TABLE_ENTRIES));
    sts_o.page_in    = (32'(page) < 32'(TABLE_ENTRIES));
    sts_o.va_nonzero = (va_q != '0);
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.left_last  = (left_q == ptcr_pkg::COUNT_W'(1));
    sts_o.e_mapped   = rdata_q[ptcr_pkg::E_MAPPED];
    sts_o.e_resident = e_resident;
    sts_o.e_accessed = rdata_q[ptcr_pkg::E_ACCESSED];
    // The last scan read lands in the decide cycle, so it is folded in here.
    sts_o.clash      = clash_q | (scan_pend_q & rdata_q[ptcr_pkg::E_MAPPED]);
    sts_o.ev_last    = (visits_q == VW'(2 * TABLE_ENTRIES - 1));
    sts_o.init_last  = (ptr_q == IW'(TABLE_ENTRIES - 1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Read address: by default the page of the request being accepted, so that
  // its entry is ready when the request is dispatched.
  always_comb begin
    priority if (cmd_i.rd_ptr) begin
      raddr = ptr_q;
    end else if (cmd_i.rd_hand) begin
      raddr = hand_q;
    end else begin
      raddr = IW'(vaddr_i[ptcr_pkg::VADDR_W-1:PAGE_OFFSET_BITS]);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = '0;
    priority if (cmd_i.clr_wr) begin
      we = 1'b1;
    end else if (cmd_i.wr_fill) begin
      we = 1'b1;
      if (op_q == ptcr_pkg::OP_MAP) begin
        wdata[ptcr_pkg::E_MAPPED] = 1'b1;
        wdata[ptcr_pkg::E_FLAGS_LSB +: ptcr_pkg::FLAGS_W] = flags_q;
      end
    end else if (cmd_i.wr_page) begin
      we    = 1'b1;
      waddr = page_idx;
      if (op_q == ptcr_pkg::OP_ACCESS) begin
        wdata = rdata_q;
        wdata[ptcr_pkg::E_ACCESSED] = 1'b1;
        wdata[ptcr_pkg::E_DIRTY]    = rdata_q[ptcr_pkg::E_DIRTY] | wr_q;
      end else begin
        wdata[ptcr_pkg::E_MAPPED:0] = rdata_q[ptcr_pkg::E_MAPPED:0];
        wdata[EW-1:ptcr_pkg::E_FRAME_LSB] = fno_q;
      end
    end else if (cmd_i.ev_visit && e_resident) begin
      we    = 1'b1;
      waddr = hand_q;
      if (rdata_q[ptcr_pkg::E_ACCESSED]) begin
        // Second chance: only the accessed bit goes.
        wdata = rdata_q;
        wdata[ptcr_pkg::E_ACCESSED] = 1'b0;
      end else begin
        wdata[ptcr_pkg::E_MAPPED:0] = rdata_q[ptcr_pkg::E_MAPPED:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_comb begin
    ptr_d    = ptr_q;
    left_d   = left_q;
    hand_d   = hand_q;
    visits_d = visits_q;
    clash_d  = clash_q;
    if (cmd_i.clr_wr) begin
      ptr_d = ptr_q + 1'b1;
    end
    if (cmd_i.ptr_init) begin
      ptr_d   = page_idx;
      left_d  = cnt_q;
      clash_d = 1'b0;
    end else if (scan_pend_q && rdata_q[ptcr_pkg::E_MAPPED]) begin
      clash_d = 1'b1;
    end
    if (cmd_i.rd_ptr || cmd_i.wr_fill) begin
      ptr_d  = ptr_q + 1'b1;
      left_d = left_q - 1'b1;
    end
    if (cmd_i.ev_start) begin
      visits_d = '0;
    end
    if (cmd_i.ev_visit) begin
      hand_d   = hand_next;
      visits_d = visits_q + 1'b1;
    end
  end

  always_comb begin
    res_st_d  = res_st_q;
    res_pa_d  = res_pa_q;
    res_vva_d = res_vva_q;
    res_vfr_d = res_vfr_q;
    res_vdt_d = res_vdt_q;
    if (cmd_i.set_res) begin
      res_pa_d  = '0;
      res_vva_d = '0;
      res_vfr_d = '0;
      res_vdt_d = 1'b0;
      unique case (cmd_i.res_kind)
        ptcr_pkg::RES_OK:       res_st_d = ptcr_pkg::ST_OK;
        ptcr_pkg::RES_TRAP:     res_st_d = ptcr_pkg::ST_TRAP;
        ptcr_pkg::RES_FAULT:    res_st_d = ptcr_pkg::ST_FAULT;
        ptcr_pkg::RES_NOVICTIM: res_st_d = ptcr_pkg::ST_NOVICTIM;
        ptcr_pkg::RES_ACCESS: begin
          res_st_d = ptcr_pkg::ST_OK;
          res_pa_d = ptcr_pkg::PHYS_W'((64'(e_frame) << PAGE_OFFSET_BITS)
                                      | 64'(va_q[PAGE_OFFSET_BITS-1:0]));
        end
        ptcr_pkg::RES_VICTIM: begin
          res_st_d  = ptcr_pkg::ST_OK;
          res_vva_d = ptcr_pkg::VADDR_W'(64'(hand_q) << PAGE_OFFSET_BITS);
          res_vfr_d = ptcr_pkg::FNUM_W'(e_frame);
          res_vdt_d = rdata_q[ptcr_pkg::E_DIRTY];
        end
        default: res_st_d = ptcr_pkg::ST_TRAP;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      left_q      <= '0;
      hand_q      <= '0;
      visits_q    <= '0;
      clash_q     <= 1'b0;
      scan_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      left_q      <= left_d;
      hand_q      <= hand_d;
      visits_q    <= visits_d;
      clash_q     <= clash_d;
      scan_pend_q <= cmd_i.rd_ptr;
      if (cmd_i.push_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_req) begin
      op_q    <= opcode_i;
      va_q    <= vaddr_i;
      wr_q    <= is_write_i;
      cnt_q   <= page_count_i;
      flags_q <= access_flags_i;
      fno_q   <= FRAME_BITS'(frame_number_i);
    end
    res_st_q  <= res_st_d;
    res_pa_q  <= res_pa_d;
    res_vva_q <= res_vva_d;
    res_vfr_q <= res_vfr_d;
    res_vdt_q <= res_vdt_d;
    if (cmd_i.push_out) begin
      out_st_q  <= res_st_q;
      out_pa_q  <= res_pa_q;
      out_vva_q <= res_vva_q;
      out_vfr_q <= res_vfr_q;
      out_vdt_q <= res_vdt_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_st_q;
  assign phys_addr_o        = out_pa_q;
  assign victim_vaddr_o     = out_vva_q;
  assign victim_frame_o     = out_vfr_q;
  assign victim_was_dirty_o = out_vdt_q;

endmodule

[rtl/page_table_clock_replacement.sv]
`timescale 1ns / 1ps
// Top level of the page table with clock (second-chance) replacement.
// Depends on ptcr_pkg, ptcr_req_if, ptcr_rsp_if, ptcr_ctrl and ptcr_dp.

// The table lives in a single memory with one write port and one registered read
// port. After reset the block clears the table, one entry at a time, and takes no
// request meanwhile. An access, an install, a rejected request or an empty run
// goes from dispatch straight to the result. Map first scans the run of pages
// for overlap and then writes each page (one scan for overlap, then one write per
// page), or stops after the scan when it finds a page already mapped; unmap writes
// each page with no scan. Evict reads and settles each entry the clock hand visits,
// at most two laps of the table when no victim is found. A new request is taken
// while the previous result still waits in the output register; a result that
// cannot leave holds the block in its final state.
module page_table_clock_replacement #(
  parameter int TABLE_ENTRIES    = 16384,
  parameter int PAGE_OFFSET_BITS = 10,
  parameter int FRAME_BITS       = 22
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptcr_req_if.sink   req_i,
  ptcr_rsp_if.source rsp_o
);

  ptcr_pkg::cmd_t cmd;
  ptcr_pkg::sts_t sts;
  logic           in_ready;

  assign req_i.ready = in_ready;

  ptcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptcr_dp #(
    .TABLE_ENTRIES    (TABLE_ENTRIES),
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
    .FRAME_BITS       (FRAME_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .opcode_i           (req_i.opcode),
    .vaddr_i            (req_i.vaddr),
    .is_write_i         (req_i.is_write),
    .page_count_i       (req_i.page_count),
    .access_flags_i     (req_i.access_flags),
    .frame_number_i     (req_i.frame_number),
    .out_ready_i        (rsp_o.ready),
    .out_valid_o        (rsp_o.valid),
    .status_o           (rsp_o.status),
    .phys_addr_o        (rsp_o.phys_addr),
    .victim_vaddr_o     (rsp_o.victim_vaddr),
    .victim_frame_o     (rsp_o.victim_frame),
    .victim_was_dirty_o (rsp_o.victim_was_dirty)
  );

endmodule

[tb/sv/tb_page_table_clock_replacement.sv]
`timescale 1ns / 1ps
// Self-checking testbench for page_table_clock_replacement: a request driver and
// a result monitor check every result against a page table kept in the bench.
// Depends on ptcr_pkg, ptcr_req_if, ptcr_rsp_if and the block under test.
module tb_page_table_clock_replacement;

  localparam int OPCODE_W         = ptcr_pkg::OPCODE_W;
  localparam int VADDR_W          = ptcr_pkg::VADDR_W;
  localparam int COUNT_W          = ptcr_pkg::COUNT_W;
  localparam int FLAGS_W          = ptcr_pkg::FLAGS_W;
  localparam int FNUM_W           = ptcr_pkg::FNUM_W;
  localparam int STATUS_W         = ptcr_pkg::STATUS_W;
  localparam int PHYS_W           = ptcr_pkg::PHYS_W;
  localparam int E_FLAGS_LSB      = ptcr_pkg::E_FLAGS_LSB;
  localparam int E_MAPPED         = ptcr_pkg::E_MAPPED;
  localparam int E_ACCESSED       = ptcr_pkg::E_ACCESSED;
  localparam int E_DIRTY          = ptcr_pkg::E_DIRTY;
  localparam int E_FRAME_LSB      = ptcr_pkg::E_FRAME_LSB;
  localparam int TABLE_ENTRIES    = 16384;
  localparam int PAGE_OFFSET_BITS = 10;
  localparam int FRAME_BITS       = 22;
  localparam int PAGE_W           = VADDR_W - PAGE_OFFSET_BITS;
  localparam int ENTRY_W          = E_FRAME_LSB + FNUM_W;
  localparam int ITEM_TARGET      = 1400;
  localparam int PHASE_LEN        = ITEM_TARGET / 3;
  localparam int BANK_STRIDE      = 1024;
  localparam int EVICT_BUDGET     = 400;
  localparam logic [OPCODE_W-1:0] OP_LAST = '1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VADDR_W-1:0]  vaddr;
    logic                is_write;
    logic [COUNT_W-1:0]  page_count;
    logic [FLAGS_W-1:0]  access_flags;
    logic [FNUM_W-1:0]   frame_number;
  } pt_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PHYS_W-1:0]   phys_addr;
    logic [VADDR_W-1:0]  victim_vaddr;
    logic [FNUM_W-1:0]   victim_frame;
    logic                victim_was_dirty;
  } pt_result_t;

  logic clk_i;
  logic rst_ni;

  ptcr_req_if req_if ();
  ptcr_rsp_if rsp_if ();

  page_table_clock_replacement #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS),
    .FRAME_BITS      (FRAME_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Bench copy of the page table and the clock hand.
  logic [ENTRY_W-1:0] pte [TABLE_ENTRIES];
  logic [PAGE_W-1:0]  hand;

  pt_request_t request_backlog [$];
  pt_result_t  owed_results [$];
  pt_request_t cur_request;
  int unsigned hot_pages [$];

  int unsigned requests_queued;
  int unsigned requests_taken;
  int unsigned results_seen;
  int unsigned n_mismatch;
  int unsigned served_by_op [8];
  int unsigned victims;
  int unsigned dirty_victims;
  logic        req_taken;

  // Applies one request to the bench page table and returns the result it owes.
  function automatic pt_result_t serve_request(pt_request_t rq);
    pt_result_t         res;
    int unsigned        pg;
    int unsigned        cnt;
    int unsigned        i;
    logic [PAGE_W-1:0]  idx;
    logic [ENTRY_W-1:0] ent;
    logic [ENTRY_W-1:0] fill;
    logic [FNUM_W-1:0]  frm;
    logic [PHYS_W-1:0]  phys;
    logic               clash;
    logic               aligned;
    logic               fits;
    logic               found;
    res = '0;
    res.status = ptcr_pkg::ST_TRAP;
    pg = 32'(rq.vaddr) >> PAGE_OFFSET_BITS;
    cnt = 32'(rq.page_count);
    aligned = (rq.vaddr[PAGE_OFFSET_BITS-1:0] == '0);
    fits = (pg <= TABLE_ENTRIES) && (cnt <= TABLE_ENTRIES - pg);
    case (rq.opcode)
      ptcr_pkg::OP_ACCESS: begin
        if (pg >= TABLE_ENTRIES) begin
          res.status = ptcr_pkg::ST_FAULT;
        end else begin
          ent = pte[pg];
          frm = ent[E_FRAME_LSB +: FNUM_W];
          if (frm == '0 || !ent[E_MAPPED]) begin
            res.status = ptcr_pkg::ST_FAULT;
          end else begin
            ent[E_ACCESSED] = 1'b1;
            if (rq.is_write) ent[E_DIRTY] = 1'b1;
            pte[pg] = ent;
            phys = PHYS_W'(frm);
            phys = (phys << PAGE_OFFSET_BITS) + PHYS_W'(rq.vaddr[PAGE_OFFSET_BITS-1:0]);
            res.phys_addr = phys;
            res.status = ptcr_pkg::ST_OK;
          end
        end
      end
      ptcr_pkg::OP_MAP: begin
        if (aligned && fits) begin
          clash = 1'b0;
          for (i = 0; i < cnt; i++) begin
            if (pte[pg + i][E_MAPPED]) clash = 1'b1;
          end
          if (!clash) begin
            fill = '0;
            fill[E_MAPPED] = 1'b1;
            fill[E_FLAGS_LSB +: FLAGS_W] = rq.access_flags;
            for (i = 0; i < cnt; i++) pte[pg + i] = fill;
            res.status = ptcr_pkg::ST_OK;
          end
        end
      end
      ptcr_pkg::OP_UNMAP: begin
        if (aligned && fits) begin
          for (i = 0; i < cnt; i++) pte[pg + i] = '0;
          res.status = ptcr_pkg::ST_OK;
        end
      end
      ptcr_pkg::OP_INSTALL: begin
        if (rq.vaddr != '0 && pg < TABLE_ENTRIES && pte[pg][E_MAPPED]) begin
          ent = pte[pg];
          ent[E_ACCESSED] = 1'b0;
          ent[E_DIRTY] = 1'b0;
          ent[E_FRAME_LSB +: FNUM_W] = rq.frame_number;
          pte[pg] = ent;
          res.status = ptcr_pkg::ST_OK;
        end
      end
      ptcr_pkg::OP_EVICT: begin
        // Second chance: accessed pages lose the bit and are passed over once.
        res.status = ptcr_pkg::ST_NOVICTIM;
        found = 1'b0;
        for (i = 0; i < 2 * TABLE_ENTRIES && !found; i++) begin
          idx = hand;
          hand = hand + 1'b1;
          ent = pte[idx];
          if (ent[E_FRAME_LSB +: FNUM_W] != '0) begin
            if (ent[E_ACCESSED]) begin
              ent[E_ACCESSED] = 1'b0;
              pte[idx] = ent;
            end else begin
              res.victim_vaddr = {idx, {PAGE_OFFSET_BITS{1'b0}}};
              res.victim_frame = ent[E_FRAME_LSB +: FNUM_W];
              res.victim_was_dirty = ent[E_DIRTY];
              ent[E_FRAME_LSB +: FNUM_W] = '0;
              ent[E_ACCESSED] = 1'b0;
              ent[E_DIRTY] = 1'b0;
              pte[idx] = ent;
              res.status = ptcr_pkg::ST_OK;
              found = 1'b1;
            end
          end
        end
      end
      default: res.status = ptcr_pkg::ST_TRAP;
    endcase
    return res;
  endfunction

  // Number of entries the next eviction would visit, without changing anything.
  function automatic int unsigned sweep_visits();
    int unsigned       j;
    int unsigned       first_resident;
    logic              seen_resident;
    logic [PAGE_W-1:0] idx;
    logic [ENTRY_W-1:0] ent;
    seen_resident = 1'b0;
    first_resident = 0;
    idx = hand;
    for (j = 0; j < TABLE_ENTRIES; j++) begin
      ent = pte[idx];
      if (ent[E_FRAME_LSB +: FNUM_W] != '0) begin
        if (!ent[E_ACCESSED]) return j + 1;
        if (!seen_resident) first_resident = j;
        seen_resident = 1'b1;
      end
      idx = idx + 1'b1;
    end
    return seen_resident ? TABLE_ENTRIES + first_resident + 1 : 2 * TABLE_ENTRIES;
  endfunction

  function automatic logic [VADDR_W-1:0] page_va(int unsigned p, int unsigned off);
    logic [31:0] pv;
    logic [31:0] ov;
    pv = p;
    ov = off;
    return {pv[PAGE_W-1:0], ov[PAGE_OFFSET_BITS-1:0]};
  endfunction

  function automatic logic [FNUM_W-1:0] rnd_frame();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 10) return '1;
    return FNUM_W'($urandom_range(1, (1 << FNUM_W) - 1));
  endfunction

  function automatic int unsigned pick_page();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60 && hot_pages.size() != 0)
      return hot_pages[$urandom_range(0, hot_pages.size() - 1)];
    if (r < 95) return $urandom_range(0, 15) * BANK_STRIDE + $urandom_range(0, 15);
    return $urandom_range(0, TABLE_ENTRIES - 1);
  endfunction

  task automatic remember_page(int unsigned p);
    hot_pages.push_back(p);
    if (hot_pages.size() > 24) void'(hot_pages.pop_front());
  endtask

  task automatic queue_request(logic [OPCODE_W-1:0] op, logic [VADDR_W-1:0] va, logic wr,
                               logic [COUNT_W-1:0] cnt, logic [FLAGS_W-1:0] flg,
                               logic [FNUM_W-1:0] frm);
    pt_request_t rq;
    rq.opcode = op;
    rq.vaddr = va;
    rq.is_write = wr;
    rq.page_count = cnt;
    rq.access_flags = flg;
    rq.frame_number = frm;
    request_backlog.push_back(rq);
    requests_queued++;
  endtask

  // Waits until every queued request has been taken, so the bench table is current.
  task automatic wait_settled();
    while (requests_taken != requests_queued) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (results_seen != requests_queued) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
    n_mismatch++;
    $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
             results_seen, what, got_v, want_v);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : reset_seq
    int unsigned i;
    for (i = 0; i < TABLE_ENTRIES; i++) pte[i] = '0;
    hand = '0;
    rst_ni = 1'b0;
    req_taken = 1'b0;
    cur_request = '0;
    req_if.valid = 1'b0;
    req_if.opcode = '0;
    req_if.vaddr = '0;
    req_if.is_write = 1'b0;
    req_if.page_count = '0;
    req_if.access_flags = '0;
    req_if.frame_number = '0;
    rsp_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d of %0d results seen", results_seen, requests_queued);
    $display("TB_ERROR");
    $finish;
  end

  always @(negedge clk_i) begin : request_driver
    pt_request_t nxt;
    logic        hold;
    int unsigned send_idle;
    int unsigned recv_idle;
    if (rst_ni) begin
      if (requests_taken < PHASE_LEN) begin
        send_idle = 7;
        recv_idle = 87;
      end else if (requests_taken < 2 * PHASE_LEN) begin
        send_idle = 87;
        recv_idle = 7;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      // A request that is still on offer stays on offer until it is taken.
      hold = req_if.valid && !req_taken;
      nxt = cur_request;
      if (!hold && request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        nxt = request_backlog.pop_front();
        hold = 1'b1;
      end
      cur_request = nxt;
      req_if.valid <= hold;
      req_if.opcode <= nxt.opcode;
      req_if.vaddr <= nxt.vaddr;
      req_if.is_write <= nxt.is_write;
      req_if.page_count <= nxt.page_count;
      req_if.access_flags <= nxt.access_flags;
      req_if.frame_number <= nxt.frame_number;
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin : channel_monitor
    pt_request_t rq;
    pt_result_t  got;
    pt_result_t  oldest;
    pt_result_t  predicted;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = rsp_if.status;
        got.phys_addr = rsp_if.phys_addr;
        got.victim_vaddr = rsp_if.victim_vaddr;
        got.victim_frame = rsp_if.victim_frame;
        got.victim_was_dirty = rsp_if.victim_was_dirty;
        if (owed_results.size() == 0) begin
          flag_mismatch("result with no request outstanding, status", got.status, 0);
        end else begin
          oldest = owed_results.pop_front();
          if (got.status !== oldest.status)
            flag_mismatch("status", got.status, oldest.status);
          if (got.phys_addr !== oldest.phys_addr)
            flag_mismatch("phys_addr", got.phys_addr, oldest.phys_addr);
          if (got.victim_vaddr !== oldest.victim_vaddr)
            flag_mismatch("victim_vaddr", got.victim_vaddr, oldest.victim_vaddr);
          if (got.victim_frame !== oldest.victim_frame)
            flag_mismatch("victim_frame", got.victim_frame, oldest.victim_frame);
          if (got.victim_was_dirty !== oldest.victim_was_dirty)
            flag_mismatch("victim_was_dirty", got.victim_was_dirty, oldest.victim_was_dirty);
        end
        results_seen <= results_seen + 1;
      end
      if (req_if.valid && req_if.ready) begin
        rq.opcode = req_if.opcode;
        rq.vaddr = req_if.vaddr;
        rq.is_write = req_if.is_write;
        rq.page_count = req_if.page_count;
        rq.access_flags = req_if.access_flags;
        rq.frame_number = req_if.frame_number;
        predicted = serve_request(rq);
        owed_results.push_back(predicted);
        served_by_op[rq.opcode]++;
        if (rq.opcode == ptcr_pkg::OP_EVICT && predicted.status == ptcr_pkg::ST_OK) begin
          victims++;
          if (predicted.victim_was_dirty) dirty_victims++;
        end
        requests_taken <= requests_taken + 1;
      end
      req_taken <= req_if.valid && req_if.ready;
    end
  end

  initial begin : stimulus
    int unsigned n_directed;
    int unsigned kind;
    int unsigned p;
    int unsigned n;
    int unsigned j;
    int unsigned off;
    logic [OPCODE_W-1:0] op;
    logic [COUNT_W-1:0]  cnt;
    requests_queued = 0;
    n_mismatch = 0;
    victims = 0;
    dirty_victims = 0;
    foreach (served_by_op[i]) served_by_op[i] = 0;

    // Directed part, starting from the empty table.
    queue_request(ptcr_pkg::OP_EVICT, '0, 1'b0, '0, '0, '0);       // nothing resident
    queue_request(ptcr_pkg::OP_ACCESS, '0, 1'b0, '0, '0, '0);      // unmapped page
    queue_request(ptcr_pkg::OP_MAP, '0, 1'b0, '0, 2'd1, '0);       // empty run
    queue_request(ptcr_pkg::OP_UNMAP, '0, 1'b0, '0, '0, '0);       // empty run
    queue_request(ptcr_pkg::OP_MAP, '0, 1'b0, 15'd4, 2'd3, '0);
    // Overlaps a mapped page.
    queue_request(ptcr_pkg::OP_MAP, page_va(2, 0), 1'b0, 15'd1, '0, '0);
    // Not page aligned.
    queue_request(ptcr_pkg::OP_MAP, page_va(8, 1), 1'b0, 15'd1, '0, '0);
    // Past the end of the table.
    queue_request(ptcr_pkg::OP_MAP, page_va(TABLE_ENTRIES - 1, 0), 1'b0, 15'd2, '0, '0);
    queue_request(ptcr_pkg::OP_MAP, page_va(TABLE_ENTRIES - 1, 0), 1'b0, 15'd1, 2'd2, '0);
    queue_request(ptcr_pkg::OP_INSTALL, '0, 1'b0, '0, '0, 22'd5);  // null address
    queue_request(ptcr_pkg::OP_INSTALL, page_va(1, 0), 1'b0, '0, '0, '1);
    queue_request(ptcr_pkg::OP_ACCESS, '0, 1'b1, '0, '0, '0);      // mapped but not resident
    queue_request(ptcr_pkg::OP_ACCESS, page_va(1, 1023), 1'b1, '0, '0, '0);
    // Page not mapped.
    queue_request(ptcr_pkg::OP_INSTALL, page_va(100, 0), 1'b0, '0, '0, 22'd9);
    queue_request(ptcr_pkg::OP_INSTALL, page_va(2, 0), 1'b0, '0, '0, '0);  // frame zero
    queue_request(ptcr_pkg::OP_INSTALL, page_va(3, 5), 1'b0, '0, '0, 22'd1);
    queue_request(ptcr_pkg::OP_ACCESS, page_va(3, 7), 1'b0, '0, '0, '0);
    queue_request(ptcr_pkg::OP_EVICT, '0, 1'b0, '0, '0, '0);       // needs a second lap
    queue_request(ptcr_pkg::OP_EVICT, '0, 1'b0, '0, '0, '0);
    // Past the end of the table.
    queue_request(ptcr_pkg::OP_UNMAP, page_va(16000, 0), 1'b0, 15'd1000, '0, '0);
    queue_request(ptcr_pkg::OP_EVICT + 3'd1, '0, 1'b0, '0, '0, '0);
    queue_request(OP_LAST, '0, 1'b0, '0, '0, '0);
    queue_request(ptcr_pkg::OP_UNMAP, '0, 1'b0, 15'(TABLE_ENTRIES), '0, '0);
    queue_request(ptcr_pkg::OP_MAP, '0, 1'b0, 15'(TABLE_ENTRIES), 2'd2, '0);
    queue_request(ptcr_pkg::OP_UNMAP, '0, 1'b0, 15'(TABLE_ENTRIES), '0, '0);
    queue_request(ptcr_pkg::OP_MAP, '1, 1'b1, '1, '1, '1);
    n_directed = requests_queued;
    // Hold the request side back until the directed results are all in.
    wait_drained();

    while (requests_queued < n_directed + ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        // Map a run, give its first pages frames and touch them.
        p = pick_page();
        n = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 4);
        if (p + n > TABLE_ENTRIES) n = TABLE_ENTRIES - p;
        queue_request(ptcr_pkg::OP_MAP, page_va(p, 0), 1'($urandom_range(0, 1)), COUNT_W'(n),
                      FLAGS_W'($urandom_range(0, 3)), rnd_frame());
        for (j = 0; j < n && j < 4; j++) begin
          queue_request(ptcr_pkg::OP_INSTALL, page_va(p + j, $urandom_range(0, 1023)),
                        1'($urandom_range(0, 1)), COUNT_W'($urandom),
                        FLAGS_W'($urandom_range(0, 3)), rnd_frame());
          remember_page(p + j);
        end
        repeat ($urandom_range(1, 3))
          queue_request(ptcr_pkg::OP_ACCESS,
                        page_va(p + $urandom_range(0, n - 1), $urandom_range(0, 1023)),
                        1'($urandom_range(0, 1)), COUNT_W'($urandom),
                        FLAGS_W'($urandom_range(0, 3)), rnd_frame());
      end else if (kind < 55) begin
        repeat ($urandom_range(2, 6))
          queue_request(ptcr_pkg::OP_ACCESS, page_va(pick_page(), $urandom_range(0, 1023)),
                        1'($urandom_range(0, 1)), COUNT_W'($urandom),
                        FLAGS_W'($urandom_range(0, 3)), rnd_frame());
      end else if (kind < 65) begin
        p = pick_page();
        n = $urandom_range(1, 3);
        if (p + n > TABLE_ENTRIES) n = TABLE_ENTRIES - p;
        queue_request(ptcr_pkg::OP_UNMAP, page_va(p, 0), 1'($urandom_range(0, 1)),
                      COUNT_W'(n), FLAGS_W'($urandom_range(0, 3)), rnd_frame());
      end else if (kind < 75) begin
        p = pick_page();
        queue_request(ptcr_pkg::OP_INSTALL, page_va(p, $urandom_range(0, 1023)),
                      1'($urandom_range(0, 1)), COUNT_W'($urandom),
                      FLAGS_W'($urandom_range(0, 3)), rnd_frame());
      end else if (kind < 88) begin
        // An eviction is only sent once the sweep it causes is known to be short;
        // otherwise a fresh resident page is placed just ahead of the hand first.
        wait_settled();
        if (sweep_visits() > EVICT_BUDGET) begin
          p = (int'(hand) + $urandom_range(1, 48)) % TABLE_ENTRIES;
          if (!pte[p][E_MAPPED])
            queue_request(ptcr_pkg::OP_MAP, page_va(p, 0), 1'b0, 15'd1,
                          FLAGS_W'($urandom_range(0, 3)), '0);
          off = $urandom_range(0, 1023);
          if (p == 0 && off == 0) off = 1;
          queue_request(ptcr_pkg::OP_INSTALL, page_va(p, off), 1'($urandom_range(0, 1)),
                        COUNT_W'($urandom), FLAGS_W'($urandom_range(0, 3)),
                        FNUM_W'($urandom_range(1, (1 << FNUM_W) - 1)));
        end
        queue_request(ptcr_pkg::OP_EVICT, VADDR_W'($urandom), 1'($urandom_range(0, 1)),
                      COUNT_W'($urandom), FLAGS_W'($urandom_range(0, 3)), rnd_frame());
      end else if (kind < 98) begin
        repeat ($urandom_range(1, 3)) begin
          op = OPCODE_W'($urandom_range(0, 6));
          if (op >= ptcr_pkg::OP_EVICT) op = op + 1'b1;
          cnt = COUNT_W'($urandom);
          if (op == ptcr_pkg::OP_MAP || op == ptcr_pkg::OP_UNMAP) begin
            // Runs are either short or too long to fit, never a long sweep.
            if ($urandom_range(0, 1) == 0) cnt = COUNT_W'($urandom_range(0, 15));
            else cnt = COUNT_W'($urandom_range(TABLE_ENTRIES + 1, (1 << COUNT_W) - 1));
          end
          queue_request(op, VADDR_W'($urandom), 1'($urandom_range(0, 1)), cnt,
                        FLAGS_W'($urandom_range(0, 3)), FNUM_W'($urandom));
        end
      end else begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (owed_results.size() != 0)
      flag_mismatch("results still outstanding", 0, owed_results.size());
    $display("Served %0d requests: %0d access, %0d map, %0d unmap, %0d install, %0d evict.",
             requests_taken, served_by_op[ptcr_pkg::OP_ACCESS],
             served_by_op[ptcr_pkg::OP_MAP], served_by_op[ptcr_pkg::OP_UNMAP],
             served_by_op[ptcr_pkg::OP_INSTALL], served_by_op[ptcr_pkg::OP_EVICT]);
    $display("Clock sweeps chose %0d victims, %0d of them dirty; %0d mismatches.",
             victims, dirty_victims, n_mismatch);
    if (n_mismatch == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
